[rtl/core/qte_pkg.sv]
// Package for the quaternion to Euler angle converter.
// Holds widths, stage counts, CORDIC constants and the arctangent table.
// No dependencies.
package qte_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int NUM_ROT      = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int SQ_STEPS     = 17;
  localparam int NUM_STG      = 2 + SQ_STEPS + 1 + NUM_ROT;

  localparam int OPW  = 34;  // product sums in Q28
  localparam int VECW = 38;  // CORDIC vector width with growth headroom
  localparam int ANGW = 34;  // Q30 angle accumulator
  localparam int POSTW = 36;

  localparam logic signed [ANGW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [POSTW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [OPW-1:0]  ONE_Q28     = 34'sd268435456;
  localparam logic signed [18:0]     ANGLE_LIMIT = 19'sd25736;

  typedef struct packed {
    logic [OPW-1:0] n;
    logic [OPW-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic signed [VECW-1:0] x;
    logic signed [VECW-1:0] y;
    logic signed [ANGW-1:0] z;
    logic                   zero;
  } cordic_t;

  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] v;
    case (i)
      0: v = 30'h3243F6A8;   1: v = 30'h1DAC6705;   2: v = 30'h0FADBAFC;
      3: v = 30'h07F56EA6;   4: v = 30'h03FEAB76;   5: v = 30'h01FFD55B;
      6: v = 30'h00FFFAAA;   7: v = 30'h007FFF55;   8: v = 30'h003FFFEA;
      9: v = 30'h001FFFFD;  10: v = 30'h000FFFFF;  11: v = 30'h0007FFFF;
      12: v = 30'h0003FFFF; 13: v = 30'h0001FFFF;  14: v = 30'h0000FFFF;
      15: v = 30'h00007FFF; 16: v = 30'h00003FFF;  17: v = 30'h00001FFF;
      18: v = 30'h00000FFF; 19: v = 30'h000007FF;  20: v = 30'h000003FF;
      21: v = 30'h000001FF; 22: v = 30'h000000FF;  23: v = 30'h0000007F;
      24: v = 30'h0000003F; 25: v = 30'h0000001F;  26: v = 30'h0000000F;
      27: v = 30'h00000008; 28: v = 30'h00000004;  29: v = 30'h00000002;
      30: v = 30'h00000001;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

  // Q30 angle to Q13 with round half up, then clamped to the angle limit.
  function automatic logic signed [15:0] to_q13(input logic signed [POSTW-1:0] z);
    logic signed [POSTW-1:0] t;
    logic signed [18:0]      r;
    t = z + 36'sd65536;
    r = 19'(t >>> 17);
    if (r > ANGLE_LIMIT) r = ANGLE_LIMIT;
    if (r < -ANGLE_LIMIT) r = -ANGLE_LIMIT;
    return r[15:0];
  endfunction

endpackage

[rtl/core/qte_if.sv]
// Handshake interfaces for quaternion items in and Euler angle items out.
// Depends on nothing.
interface quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface euler_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

[rtl/core/quaternion_to_euler_top.sv]
// Quaternion to roll, pitch, yaw converter: products, square root cells, CORDIC cells.
// Throughput: one item per cycle; the whole chain stalls only when a result waits
// in the output register and the last stage also holds an item.
// Reset clears the valid bits of every stage and the output register.
// Depends on qte_pkg, qte_if, qte_sqrt_cell and qte_cordic_cell.
module quaternion_to_euler_top
  import qte_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  quat_if.sink    quat_i,
  euler_if.source euler_o
);
  logic                 take, en;
  logic [NUM_STG-1:0]   vld_q;

  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, zz_q, wz_q, xy_q, wy_q, xz_q;
  logic signed [OPW-1:0] rs_q, rc_q, ys_q, yc_q;
  logic signed [OPW-1:0] t2, av, bv;
  sqrt_t sa [SQ_STEPS+1];
  sqrt_t sb [SQ_STEPS+1];
  logic signed [OPW-1:0] drs_q [SQ_STEPS];
  logic signed [OPW-1:0] drc_q [SQ_STEPS];
  logic signed [OPW-1:0] dys_q [SQ_STEPS];
  logic signed [OPW-1:0] dyc_q [SQ_STEPS];
  cordic_t cr [NUM_ROT+1];
  cordic_t cp [NUM_ROT+1];
  cordic_t cy [NUM_ROT+1];
  logic signed [15:0] roll_q, pitch_q, yaw_q;
  logic               out_vld_q;
  logic signed [POSTW-1:0] zr, zp, zy;

  assign take = !out_vld_q || euler_o.ready;
  assign en   = take || !vld_q[NUM_STG-1];
  assign quat_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NUM_STG-2:0], quat_i.valid};
    end
  end

  // Stage 1: all products.
  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= quat_i.quat_w * quat_i.quat_x;
      yz_q <= quat_i.quat_y * quat_i.quat_z;
      xx_q <= quat_i.quat_x * quat_i.quat_x;
      yy_q <= quat_i.quat_y * quat_i.quat_y;
      zz_q <= quat_i.quat_z * quat_i.quat_z;
      wz_q <= quat_i.quat_w * quat_i.quat_z;
      xy_q <= quat_i.quat_x * quat_i.quat_y;
      wy_q <= quat_i.quat_w * quat_i.quat_y;
      xz_q <= quat_i.quat_x * quat_i.quat_z;
    end
  end

  // Stage 2: atan2 operands and the clamped square root arguments.
  always_comb begin
    t2 = (OPW'(wy_q) - OPW'(xz_q)) <<< 1;
    av = ONE_Q28 + t2;
    bv = ONE_Q28 - t2;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rs_q      <= (OPW'(wx_q) + OPW'(yz_q)) <<< 1;
      rc_q      <= ONE_Q28 - ((OPW'(xx_q) + OPW'(yy_q)) <<< 1);
      ys_q      <= (OPW'(wz_q) + OPW'(xy_q)) <<< 1;
      yc_q      <= ONE_Q28 - ((OPW'(yy_q) + OPW'(zz_q)) <<< 1);
      sa[0].n   <= av[OPW-1] ? '0 : av;
      sb[0].n   <= bv[OPW-1] ? '0 : bv;
      sa[0].res <= '0;
      sb[0].res <= '0;
    end
  end

  // Square root chain; the roll and yaw operands ride alongside.
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    localparam logic [OPW-1:0] BitK = OPW'(1) << (2 * (SQ_STEPS - 1 - k));
    qte_sqrt_cell u_sa (.clk_i, .en_i(en), .bit_i(BitK), .in_i(sa[k]), .out_o(sa[k+1]));
    qte_sqrt_cell u_sb (.clk_i, .en_i(en), .bit_i(BitK), .in_i(sb[k]), .out_o(sb[k+1]));
    always_ff @(posedge clk_i) begin
      if (en) begin
        drs_q[k] <= (k == 0) ? rs_q : drs_q[(k == 0) ? 0 : k-1];
        drc_q[k] <= (k == 0) ? rc_q : drc_q[(k == 0) ? 0 : k-1];
        dys_q[k] <= (k == 0) ? ys_q : dys_q[(k == 0) ? 0 : k-1];
        dyc_q[k] <= (k == 0) ? yc_q : dyc_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // A vector in the left half plane is turned by pi before the rotations.
  function automatic cordic_t prerot(input logic signed [OPW-1:0] s,
                                     input logic signed [OPW-1:0] c);
    cordic_t r;
    r.zero = (s == '0) && (c == '0);
    if (c < 0) begin
      r.x = -VECW'(c);
      r.y = -VECW'(s);
      r.z = (s >= 0) ? PI_Q30 : -PI_Q30;
    end else begin
      r.x = VECW'(c);
      r.y = VECW'(s);
      r.z = '0;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      cr[0] <= prerot(drs_q[SQ_STEPS-1], drc_q[SQ_STEPS-1]);
      cy[0] <= prerot(dys_q[SQ_STEPS-1], dyc_q[SQ_STEPS-1]);
      cp[0] <= prerot($signed(sa[SQ_STEPS].res), $signed(sb[SQ_STEPS].res));
    end
  end

  for (genvar i = 0; i < NUM_ROT; i++) begin : g_rot
    localparam logic [4:0]  ShiftI = 5'(i);
    localparam logic [29:0] AtanI  = atan_q30(i);
    qte_cordic_cell u_r (.clk_i, .en_i(en), .shift_i(ShiftI), .atan_i(AtanI),
                         .in_i(cr[i]), .out_o(cr[i+1]));
    qte_cordic_cell u_p (.clk_i, .en_i(en), .shift_i(ShiftI), .atan_i(AtanI),
                         .in_i(cp[i]), .out_o(cp[i+1]));
    qte_cordic_cell u_y (.clk_i, .en_i(en), .shift_i(ShiftI), .atan_i(AtanI),
                         .in_i(cy[i]), .out_o(cy[i+1]));
  end

  always_comb begin
    zr = cr[NUM_ROT].zero ? '0 : POSTW'(cr[NUM_ROT].z);
    zy = cy[NUM_ROT].zero ? '0 : POSTW'(cy[NUM_ROT].z);
    zp = (cp[NUM_ROT].zero ? '0 : (POSTW'(cp[NUM_ROT].z) <<< 1)) - HALF_PI_Q30;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (take) begin
      out_vld_q <= vld_q[NUM_STG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && vld_q[NUM_STG-1]) begin
      roll_q  <= to_q13(zr);
      pitch_q <= to_q13(zp);
      yaw_q   <= to_q13(zy);
    end
  end

  assign euler_o.valid       = out_vld_q;
  assign euler_o.roll_angle  = roll_q;
  assign euler_o.pitch_angle = pitch_q;
  assign euler_o.yaw_angle   = yaw_q;
endmodule

[rtl/core/qte_sqrt_cell.sv]
// One digit cell of the pipelined integer square root.
// Depends on qte_pkg.
module qte_sqrt_cell
  import qte_pkg::*;
(
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [OPW-1:0] bit_i,
  input  sqrt_t          in_i,
  output sqrt_t          out_o
);
  sqrt_t          out_d, out_q;
  logic [OPW-1:0] trial;

  always_comb begin
    trial = in_i.res + bit_i;
    if (in_i.n >= trial) begin
      out_d.n   = in_i.n - trial;
      out_d.res = (in_i.res >> 1) + bit_i;
    end else begin
      out_d.n   = in_i.n;
      out_d.res = in_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) out_q <= out_d;
  end

  assign out_o = out_q;
endmodule

[rtl/core/qte_cordic_cell.sv]
// One vectoring step of the pipelined CORDIC arctangent.
// Depends on qte_pkg.
module qte_cordic_cell
  import qte_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [4:0]  shift_i,
  input  logic [29:0] atan_i,
  input  cordic_t     in_i,
  output cordic_t     out_o
);
  cordic_t                out_d, out_q;
  logic signed [VECW-1:0] xs, ys;
  logic signed [ANGW-1:0] da;

  always_comb begin
    xs = in_i.x >>> shift_i;
    ys = in_i.y >>> shift_i;
    da = $signed({{(ANGW-30){1'b0}}, atan_i});
    out_d.zero = in_i.zero;
    if (in_i.y > 0) begin
      out_d.x = in_i.x + ys;
      out_d.y = in_i.y - xs;
      out_d.z = in_i.z + da;
    end else begin
      out_d.x = in_i.x - ys;
      out_d.y = in_i.y + xs;
      out_d.z = in_i.z - da;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) out_q <= out_d;
  end

  assign out_o = out_q;
endmodule

[rtl/core/qte_checker.sv]
// Port level checks for the quaternion to Euler converter, bound to the top level.
// Depends on qte_if and quaternion_to_euler_top.
module qte_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] roll,
  input logic signed [15:0] pitch,
  input logic signed [15:0] yaw
);
  // An empty output register never holds back the input side.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready) else $error("input stalled with empty output");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(roll) && $stable(pitch) && $stable(yaw))
    else $error("stalled result changed");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> roll <= 16'sd25736 && roll >= -16'sd25736 &&
                  pitch <= 16'sd25736 && pitch >= -16'sd25736 &&
                  yaw <= 16'sd25736 && yaw >= -16'sd25736)
    else $error("angle beyond limit");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid) else $error("result valid after reset");
endmodule

bind quaternion_to_euler_top qte_checker u_qte_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (quat_i.ready),
  .out_valid (euler_o.valid),
  .out_ready (euler_o.ready),
  .roll      (euler_o.roll_angle),
  .pitch     (euler_o.pitch_angle),
  .yaw       (euler_o.yaw_angle)
);

[tb/sv/tb.sv]
// Testbench for quaternion_to_euler_top: random and directed quaternions with a
// bit-exact integer predictor of roll, pitch and yaw, checked in order.
// Depends on qte_pkg, qte_if and the RTL of quaternion_to_euler_top.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qte_pkg::*;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } euler_t;

  localparam int LATENCY = 40;
  localparam longint CYCLE_LIMIT = 600000;

  logic clk_i;
  logic rst_ni;
  quat_if  quat_i ();
  euler_if euler_o ();

  quaternion_to_euler_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .quat_i (quat_i.sink),
    .euler_o(euler_o.source)
  );

  quat_t  pending_quats[$];
  euler_t expected_angles[$];
  int     send_idle_pct;
  int     recv_stall_pct;
  bit     hold_recv;
  bit     in_taken;
  int     mismatches;
  longint cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Flooring right shift of a signed value.
  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(input longint a);
    longint unsigned n, res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    if (a <= 0) return 0;
    n = a;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic longint vector_angle(input longint yv, input longint xv);
    longint acc, nx, ny, xs, ys;
    int steps;
    acc = 0;
    xs = xv;
    ys = yv;
    steps = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    if (xs == 0 && ys == 0) return 0;
    if (xs < 0) begin
      acc = (ys >= 0) ? 64'sd3373259426 : -64'sd3373259426;
      xs = -xs;
      ys = -ys;
    end
    for (int i = 0; i < steps; i++) begin
      if (ys > 0) begin
        nx = xs + floor_shr(ys, i);
        ny = ys - floor_shr(xs, i);
        acc += longint'(atan_q30(i));
      end else begin
        nx = xs - floor_shr(ys, i);
        ny = ys + floor_shr(xs, i);
        acc -= longint'(atan_q30(i));
      end
      xs = nx;
      ys = ny;
    end
    return acc;
  endfunction

  function automatic logic signed [15:0] angle_q13(input longint a);
    longint r;
    r = floor_shr(a + 65536, 17);
    if (r > 25736) r = 25736;
    if (r < -25736) r = -25736;
    return r[15:0];
  endfunction

  function automatic euler_t quat_to_euler(input quat_t q);
    longint w, x, y, z, s, c, t, ra, rb;
    euler_t e;
    w = q.w;
    x = q.x;
    y = q.y;
    z = q.z;
    s = 2 * (w * x + y * z);
    c = 268435456 - 2 * (x * x + y * y);
    e.roll = angle_q13(vector_angle(s, c));
    t = w * y - x * z;
    ra = int_sqrt(268435456 + 2 * t);
    rb = int_sqrt(268435456 - 2 * t);
    e.pitch = angle_q13(2 * vector_angle(ra, rb) - 64'sd1686629713);
    s = 2 * (w * z + x * y);
    c = 268435456 - 2 * (y * y + z * z);
    e.yaw = angle_q13(vector_angle(s, c));
    return e;
  endfunction

  // Driver: offers the next pending item, drops it once accepted.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_i.valid <= 1'b0;
      quat_i.quat_w <= '0;
      quat_i.quat_x <= '0;
      quat_i.quat_y <= '0;
      quat_i.quat_z <= '0;
      euler_o.ready <= 1'b0;
    end else begin
      if (!quat_i.valid || in_taken) begin
        if (in_taken) void'(pending_quats.pop_front());
        if (pending_quats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          quat_i.valid  <= 1'b1;
          quat_i.quat_w <= pending_quats[0].w;
          quat_i.quat_x <= pending_quats[0].x;
          quat_i.quat_y <= pending_quats[0].y;
          quat_i.quat_z <= pending_quats[0].z;
        end else begin
          quat_i.valid <= 1'b0;
        end
      end
      euler_o.ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on input acceptance and checks each accepted result.
  always @(posedge clk_i) begin
    euler_t got, want;
    in_taken <= rst_ni && quat_i.valid && quat_i.ready;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (quat_i.valid && quat_i.ready)
        expected_angles.push_back(quat_to_euler({quat_i.quat_w, quat_i.quat_x,
                                                 quat_i.quat_y, quat_i.quat_z}));
      if (euler_o.valid && euler_o.ready) begin
        got = {euler_o.roll_angle, euler_o.pitch_angle, euler_o.yaw_angle};
        if (expected_angles.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %h", got);
        end else begin
          want = expected_angles.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d (exp/got)",
                       want.roll, got.roll, want.pitch, got.pitch, want.yaw, got.yaw);
          end
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic signed [15:0] rand_comp();
    int sel;
    sel = $urandom_range(99);
    if (sel < 5) return 16'($urandom);
    if (sel < 10) begin
      case ($urandom_range(4))
        0: return -16'sd32768;
        1: return 16'sd32767;
        2: return 16'sd16384;
        3: return -16'sd16384;
        default: return 16'sd0;
      endcase
    end
    return 16'(int'($urandom_range(32768)) - 16384);
  endfunction

  // Mostly near-unit quaternions: a random direction scaled to length one.
  function automatic quat_t rand_quat();
    quat_t q;
    real a, b, c, d, n;
    if ($urandom_range(99) < 30) begin
      q = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
    end else begin
      a = real'(int'($urandom_range(2000)) - 1000);
      b = real'(int'($urandom_range(2000)) - 1000);
      c = real'(int'($urandom_range(2000)) - 1000);
      d = real'(int'($urandom_range(2000)) - 1000);
      if ($urandom_range(9) == 0) c = 0.0;
      n = $sqrt(a * a + b * b + c * c + d * d) + 1.0e-9;
      q.w = 16'($rtoi(16384.0 * a / n));
      q.x = 16'($rtoi(16384.0 * b / n));
      q.y = 16'($rtoi(16384.0 * c / n));
      q.z = 16'($rtoi(16384.0 * d / n));
    end
    return q;
  endfunction

  task automatic drain();
    while (pending_quats.size() > 0 || expected_angles.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    quat_t q;
    hold_recv = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    cycles = 0;
    quat_i.valid = 1'b0;
    quat_i.quat_w = '0;
    quat_i.quat_x = '0;
    quat_i.quat_y = '0;
    quat_i.quat_z = '0;
    euler_o.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: identity, zero vector, extremes, gimbal lock, non-unit.
    pending_quats.push_back({16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    pending_quats.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd0});
    pending_quats.push_back({-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
    pending_quats.push_back({16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
    pending_quats.push_back({16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768});
    pending_quats.push_back({16'sd11585, 16'sd0, 16'sd11585, 16'sd0});
    pending_quats.push_back({16'sd11585, 16'sd0, -16'sd11585, 16'sd0});
    pending_quats.push_back({16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192});
    pending_quats.push_back({16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192});
    pending_quats.push_back({16'sd0, 16'sd16384, 16'sd0, 16'sd0});
    pending_quats.push_back({16'sd0, 16'sd0, 16'sd16384, 16'sd0});
    pending_quats.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd16384});
    pending_quats.push_back({16'sd0, -16'sd16384, 16'sd0, 16'sd0});
    pending_quats.push_back({16'sd16384, 16'sd16384, 16'sd16384, -16'sd16384});
    pending_quats.push_back({-16'sd16384, 16'sd0, 16'sd16384, 16'sd0});
    pending_quats.push_back({16'sd0, 16'sd11585, 16'sd0, -16'sd11585});
    pending_quats.push_back({16'sd1, -16'sd1, 16'sd1, -16'sd1});
    pending_quats.push_back({16'sd0, 16'sd0, 16'sd0, -16'sd1});
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 54 : (phase == 3) ? 29 : 0;
      recv_stall_pct = (phase == 2) ? 54 : (phase == 3) ? 29 : 0;
      for (int k = 0; k < 450; k++) pending_quats.push_back(rand_quat());
      if (phase == 0) begin
        // Long receiver hold-off so the pipeline fills and stalls its input.
        fork
          begin
            hold_recv = 1'b1;
            repeat (120) @(posedge clk_i);
            hold_recv = 1'b0;
          end
        join_none
      end
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int k = 0; k < 130; k++) pending_quats.push_back(rand_quat());
    drain();

    repeat (LATENCY) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[quaternion_to_euler_top.f]
rtl/core/qte_pkg.sv
rtl/core/qte_if.sv
rtl/core/qte_sqrt_cell.sv
rtl/core/qte_cordic_cell.sv
rtl/core/quaternion_to_euler_top.sv
rtl/core/qte_checker.sv
tb/sv/tb.sv
